// ===== rtl/generational_handle_table_unit_assert.svh =====
// Assertion macros shared by the handle table RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef GENERATIONAL_HANDLE_TABLE_UNIT_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define GHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define GHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ===== rtl/ght_pkg.sv =====
// Shared opcodes and constants for the handle table.
// Depends on nothing.
`timescale 1ns / 1ps
package ght_pkg;
	localparam logic [2:0] OP_BIND     = 3'd0;
	localparam logic [2:0] OP_UNBIND   = 3'd1;
	localparam logic [2:0] OP_ALLOCATE = 3'd2;
	localparam logic [2:0] OP_RELEASE  = 3'd3;
	localparam logic [2:0] OP_RESOLVE  = 3'd4;
	localparam logic [2:0] OP_CLEAR    = 3'd5;
	localparam logic [31:0] NULL_ENTITY = 32'hFFFF_FFFF;
endpackage

// ===== rtl/ght_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/generational_handle_table_unit.sv =====
// Generational handle table: slot map with a free queue, top level.
// Uses ght_pkg, ght_ram and the assertion macro header.
//
// Usage: drive opcode, actor_id and entity with start high while busy is
// low; the word is taken at that edge and busy rises at once. Exactly one
// result word follows, shown for one cycle with done high on ok, id_out and
// entity_out; the receiver cannot stall it and must take it then.
// Resolve, unbind and release decide, read the slot, act on it and respond.
// Bind also passes the grow state for each slot it creates while growing the
// table (up to 2^INDEX_BITS slots). Allocate reads the queue head, checks the
// index and reads and modifies its slot, skipping indexes that are zero, beyond
// the table or not free; with the queue empty it appends a slot, and with the
// table full it fails. Clear, a bad id, a null entity and unused opcodes answer
// from decide. The slot RAM and queue RAM set the pace, each read-then-written
// through one port with a registered read. busy falls together with done, so
// the next word can be taken at the edge that ends the done cycle. Reset clears
// the slot count and queue pointers at once; no clearing pass runs because
// slots are initialized when the table grows over them.
`timescale 1ns / 1ps
`include "generational_handle_table_unit_assert.svh"
module generational_handle_table_unit #(
	parameter int INDEX_BITS = 8,
	parameter int GEN_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [15:0] actor_id,
	input  logic [31:0] entity,
	output logic        done,
	output logic        ok,
	output logic [15:0] id_out,
	output logic [31:0] entity_out
);
	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int SW = GEN_BITS + 34;
	localparam int PW = INDEX_BITS + GEN_BITS;
	typedef logic [INDEX_BITS-1:0] idx_t;
	typedef logic [INDEX_BITS:0] cnt_t;
	typedef logic [GEN_BITS-1:0] gen_t;
	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_RD, S_MOD, S_GROW, S_QRD, S_QCHK, S_CRD, S_CMOD, S_NEW, S_RESP
	} state_t;

	state_t state_q;
	logic [2:0] op_q;
	idx_t idx_q;
	gen_t gen_q;
	logic [31:0] ent_q;
	cnt_t slot_count_q, grow_q, queue_count_q;
	idx_t head_q, tail_q;
	logic ok_q;
	logic [15:0] id_q;
	logic [31:0] eout_q;

	// Slot word: {generation, entity, reserved, retired}.
	logic s_we;
	idx_t s_addr;
	logic [SW-1:0] s_wdata, s_rdata;
	logic q_we;
	idx_t q_addr;
	idx_t q_wdata, q_rdata;

	ght_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_slot (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
	ght_ram #(.WIDTH(INDEX_BITS), .DEPTH(DEPTH)) u_queue (
		.clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata));

	gen_t r_gen;
	logic [31:0] r_ent;
	logic r_res, r_ret;
	assign r_gen = s_rdata[SW-1 -: GEN_BITS];
	assign r_ent = s_rdata[33:2];
	assign r_res = s_rdata[1];
	assign r_ret = s_rdata[0];

	idx_t in_idx;
	gen_t in_gen;
	logic [PW-1:0] in_id;
	logic id_good;
	cnt_t idx_ext, cnt_plus;
	idx_t q_idx;
	logic [PW-1:0] new_id;
	gen_t gen_one, alloc_gen;
	assign in_id = PW'(actor_id);
	assign in_idx = in_id[INDEX_BITS-1:0];
	assign in_gen = in_id[PW-1 -: GEN_BITS];
	assign id_good = (idx_q != '0) && (gen_q != '0);
	assign idx_ext = {1'b0, idx_q};
	assign cnt_plus = slot_count_q + cnt_t'(1);
	assign q_idx = q_rdata;
	assign gen_one = gen_t'(1);
	assign alloc_gen = (r_gen == '0) ? gen_one : r_gen;
	assign new_id = {alloc_gen, idx_q};

	logic [SW-1:0] fresh;
	assign fresh = {{GEN_BITS{1'b0}}, ght_pkg::NULL_ENTITY, 2'b00};

	always_comb begin
		s_we = 1'b0;
		s_addr = idx_q;
		s_wdata = fresh;
		q_we = 1'b0;
		q_addr = head_q;
		q_wdata = grow_q[INDEX_BITS-1:0];
		unique case (state_q)
			S_DECIDE: begin
				// Create reserved, retired slot zero on first use.
				if ((op_q == ght_pkg::OP_BIND || op_q == ght_pkg::OP_ALLOCATE) &&
						slot_count_q == '0 && ent_q != ght_pkg::NULL_ENTITY) begin
					s_we = 1'b1;
					s_addr = '0;
					s_wdata = {{GEN_BITS{1'b0}}, ght_pkg::NULL_ENTITY, 2'b11};
				end
			end
			S_GROW: begin
				s_we = 1'b1;
				s_addr = grow_q[INDEX_BITS-1:0];
				if (grow_q[INDEX_BITS-1:0] != idx_q && queue_count_q <= cnt_t'(DEPTH - 1)) begin
					q_we = 1'b1;
					q_addr = tail_q;
				end
			end
			S_MOD: begin
				unique case (op_q)
					ght_pkg::OP_BIND: begin
						s_we = !r_ret && r_ent == ght_pkg::NULL_ENTITY;
						s_wdata = {gen_q, ent_q, 1'b1, r_ret};
					end
					ght_pkg::OP_UNBIND: begin
						s_we = r_ent != ght_pkg::NULL_ENTITY && r_gen == gen_q && r_res;
						s_wdata = {r_gen, ght_pkg::NULL_ENTITY, r_res, r_ret};
					end
					ght_pkg::OP_RELEASE: begin
						s_we = r_ent != ght_pkg::NULL_ENTITY && r_gen == gen_q && !r_res && !r_ret;
						if (&r_gen) begin
							s_wdata = {r_gen, ght_pkg::NULL_ENTITY, 1'b0, 1'b1};
						end else begin
							s_wdata = {r_gen + gen_one, ght_pkg::NULL_ENTITY, 1'b0, 1'b0};
							q_we = s_we && queue_count_q <= cnt_t'(DEPTH - 1);
							q_addr = tail_q;
							q_wdata = idx_q;
						end
					end
					default: ;
				endcase
			end
			S_NEW: begin
				s_we = 1'b1;
				s_addr = slot_count_q[INDEX_BITS-1:0];
			end
			S_CMOD: begin
				s_we = r_ent == ght_pkg::NULL_ENTITY && !r_res && !r_ret;
				s_wdata = {alloc_gen, ent_q, 1'b0, r_ret};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_count_q <= '0;
			queue_count_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			grow_q <= '0;
			done <= 1'b0;
			ok_q <= 1'b0;
			id_q <= '0;
			eout_q <= ght_pkg::NULL_ENTITY;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= opcode;
						idx_q <= in_idx;
						gen_q <= in_gen;
						ent_q <= entity;
						ok_q <= 1'b0;
						id_q <= '0;
						eout_q <= ght_pkg::NULL_ENTITY;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_RESP;
					unique case (op_q)
						ght_pkg::OP_BIND: begin
							if (ent_q != ght_pkg::NULL_ENTITY && id_good) begin
								if (slot_count_q == '0) begin
									slot_count_q <= cnt_t'(1);
									grow_q <= cnt_t'(1);
								end else begin
									grow_q <= slot_count_q;
								end
								if (idx_ext >= slot_count_q || slot_count_q == '0) begin
									state_q <= S_GROW;
								end else begin
									state_q <= S_RD;
								end
							end
						end
						ght_pkg::OP_UNBIND, ght_pkg::OP_RELEASE, ght_pkg::OP_RESOLVE: begin
							if (id_good && idx_ext < slot_count_q) begin
								state_q <= S_RD;
							end
						end
						ght_pkg::OP_ALLOCATE: begin
							if (ent_q != ght_pkg::NULL_ENTITY) begin
								if (slot_count_q == '0) begin
									slot_count_q <= cnt_t'(1);
								end
								state_q <= S_QRD;
							end
						end
						ght_pkg::OP_CLEAR: begin
							slot_count_q <= '0;
							queue_count_q <= '0;
							head_q <= '0;
							tail_q <= '0;
							ok_q <= 1'b1;
						end
						default: ;
					endcase
				end
				S_GROW: begin
					if (q_we) begin
						tail_q <= tail_q + idx_t'(1);
						queue_count_q <= queue_count_q + cnt_t'(1);
					end
					grow_q <= grow_q + cnt_t'(1);
					if (grow_q[INDEX_BITS-1:0] == idx_q) begin
						slot_count_q <= idx_ext + cnt_t'(1);
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_MOD;
				S_MOD: begin
					state_q <= S_RESP;
					unique case (op_q)
						ght_pkg::OP_BIND: begin
							if (!r_ret) begin
								ok_q <= (r_ent == ght_pkg::NULL_ENTITY) ||
									(r_gen == gen_q && r_ent == ent_q);
							end
						end
						ght_pkg::OP_RESOLVE: begin
							if (r_gen == gen_q) begin
								eout_q <= r_ent;
								ok_q <= r_ent != ght_pkg::NULL_ENTITY;
							end
						end
						ght_pkg::OP_UNBIND: ok_q <= s_we;
						ght_pkg::OP_RELEASE: begin
							ok_q <= s_we;
							if (q_we) begin
								tail_q <= tail_q + idx_t'(1);
								queue_count_q <= queue_count_q + cnt_t'(1);
							end
						end
						default: ;
					endcase
				end
				S_QRD: begin
					if (queue_count_q == '0) begin
						state_q <= S_NEW;
					end else begin
						head_q <= head_q + idx_t'(1);
						queue_count_q <= queue_count_q - cnt_t'(1);
						state_q <= S_QCHK;
					end
				end
				S_QCHK: begin
					idx_q <= q_idx;
					if ({1'b0, q_idx} < slot_count_q && q_idx != '0) begin
						state_q <= S_CRD;
					end else begin
						state_q <= S_QRD;
					end
				end
				S_CRD: state_q <= S_CMOD;
				S_CMOD: begin
					// Slot index and address both follow idx_q from here.
					if (r_ent == ght_pkg::NULL_ENTITY && !r_res && !r_ret) begin
						ok_q <= 1'b1;
						id_q <= 16'(new_id);
						state_q <= S_RESP;
					end else begin
						state_q <= S_QRD;
					end
				end
				S_NEW: begin
					if (slot_count_q > cnt_t'(DEPTH - 1)) begin
						state_q <= S_RESP;
					end else begin
						idx_q <= slot_count_q[INDEX_BITS-1:0];
						slot_count_q <= cnt_plus;
						state_q <= S_CRD;
					end
				end
				S_RESP: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// S_CMOD writes to idx_q and S_CRD reads from idx_q, so both see the same slot.
	assign busy = state_q != S_IDLE;
	assign ok = ok_q;
	assign id_out = id_q;
	assign entity_out = eout_q;

	`GHT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, queue_count_q <= cnt_t'(DEPTH))
	`GHT_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`GHT_ASSERT_IMP(a_fail_no_id, clk, arst_n, done && !ok, id_out == '0)
endmodule

// ===== bench/tb_generational_handle_table_unit.sv =====
// Testbench for generational_handle_table_unit: directed and random command words.
// Checks each result word against a behavioral slot map model.
// Depends on ght_pkg and the handle table RTL.
`timescale 1ns / 1ps
module tb_generational_handle_table_unit;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	class handle_table_scoreboard;
		typedef struct packed {
			logic        ok;
			logic [15:0] id;
			logic [31:0] ent;
		} answer_t;

		logic [7:0]  slot_gen [256];
		logic [31:0] slot_ent [256];
		bit          slot_rsv [256];
		bit          slot_ret [256];
		int unsigned slot_count;
		logic [7:0]  free_list [$];
		answer_t     pending [$];
		int          errors;
		logic [15:0] last_id;

		function void empty_table();
			slot_count = 0;
			free_list.delete();
		endfunction

		function void init_slot(int unsigned i, bit rsv, bit ret);
			slot_gen[i] = 8'd0;
			slot_ent[i] = ght_pkg::NULL_ENTITY;
			slot_rsv[i] = rsv;
			slot_ret[i] = ret;
		endfunction

		function void ensure_slot_zero();
			if (slot_count == 0) begin
				init_slot(0, 1'b1, 1'b1);
				slot_count = 1;
			end
		endfunction

		function void push_free(int unsigned i);
			if (free_list.size() < 256)
				free_list.insert(free_list.size(), i[7:0]);
		endfunction

		// Works out the result word for one accepted command word.
		function void note(logic [2:0] op, logic [15:0] id, logic [31:0] ent);
			answer_t a;
			int unsigned idx;
			int unsigned g;
			int unsigned pick;
			int unsigned c;
			bit id_good;
			bit fail;
			a.ok = 1'b0;
			a.id = 16'd0;
			a.ent = ght_pkg::NULL_ENTITY;
			idx = id[7:0];
			g = id[15:8];
			id_good = (idx != 0) && (g != 0);
			case (op)
				ght_pkg::OP_BIND: begin
					if (ent != ght_pkg::NULL_ENTITY && id_good) begin
						ensure_slot_zero();
						if (idx >= slot_count) begin
							for (int unsigned i = slot_count; i <= idx; i++) begin
								init_slot(i, 1'b0, 1'b0);
								if (i < idx)
									push_free(i);
							end
							slot_count = idx + 1;
						end
						if (!slot_ret[idx]) begin
							if (slot_ent[idx] != ght_pkg::NULL_ENTITY) begin
								a.ok = (slot_gen[idx] == g) && (slot_ent[idx] == ent);
							end else begin
								slot_gen[idx] = g;
								slot_ent[idx] = ent;
								slot_rsv[idx] = 1'b1;
								a.ok = 1'b1;
							end
						end
					end
				end
				ght_pkg::OP_UNBIND: begin
					if (id_good && idx < slot_count && slot_ent[idx] != ght_pkg::NULL_ENTITY &&
							slot_gen[idx] == g && slot_rsv[idx]) begin
						slot_ent[idx] = ght_pkg::NULL_ENTITY;
						a.ok = 1'b1;
					end
				end
				ght_pkg::OP_ALLOCATE: begin
					if (ent != ght_pkg::NULL_ENTITY) begin
						ensure_slot_zero();
						pick = 0;
						fail = 1'b0;
						// Stale queue entries are dropped on the way to a usable one.
						while (free_list.size() != 0 && pick == 0) begin
							c = free_list[0];
							free_list.delete(0);
							if (c < slot_count && slot_ent[c] == ght_pkg::NULL_ENTITY &&
									!slot_rsv[c] && !slot_ret[c])
								pick = c;
						end
						if (pick == 0) begin
							if (slot_count > 255) begin
								fail = 1'b1;
							end else begin
								pick = slot_count;
								init_slot(pick, 1'b0, 1'b0);
								slot_count++;
							end
						end
						if (!fail) begin
							if (slot_gen[pick] == 0)
								slot_gen[pick] = 8'd1;
							slot_ent[pick] = ent;
							slot_rsv[pick] = 1'b0;
							a.id = {slot_gen[pick], pick[7:0]};
							a.ok = 1'b1;
						end
					end
				end
				ght_pkg::OP_RELEASE: begin
					if (id_good && idx < slot_count && slot_ent[idx] != ght_pkg::NULL_ENTITY &&
							slot_gen[idx] == g && !slot_rsv[idx] && !slot_ret[idx]) begin
						slot_ent[idx] = ght_pkg::NULL_ENTITY;
						a.ok = 1'b1;
						if (slot_gen[idx] == 8'hFF) begin
							slot_ret[idx] = 1'b1;
						end else begin
							slot_gen[idx]++;
							push_free(idx);
						end
					end
				end
				ght_pkg::OP_RESOLVE: begin
					if (id_good && idx < slot_count) begin
						if (slot_gen[idx] == g)
							a.ent = slot_ent[idx];
						a.ok = (a.ent != ght_pkg::NULL_ENTITY);
					end
				end
				ght_pkg::OP_CLEAR: begin
					empty_table();
					a.ok = 1'b1;
				end
				default: ;
			endcase
			last_id = a.id;
			pending.insert(pending.size(), a);
		endfunction

		function void check(logic ok, logic [15:0] id, logic [31:0] ent);
			answer_t a;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result word: ok %0b id %h entity %h", ok, id, ent);
				return;
			end
			a = pending[0];
			pending.delete(0);
			if (ok !== a.ok || id !== a.id || ent !== a.ent) begin
				errors++;
				if (errors <= 10)
					$display("Mismatch: expected ok %0b id %h entity %h, got ok %0b id %h entity %h",
						a.ok, a.id, a.ent, ok, id, ent);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	logic [15:0] actor_id;
	logic [31:0] entity;
	logic        done;
	logic        ok;
	logic [15:0] id_out;
	logic [31:0] entity_out;

	handle_table_scoreboard table_model;
	logic [15:0] handles [$];

	generational_handle_table_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .actor_id(actor_id), .entity(entity),
		.done(done), .ok(ok), .id_out(id_out), .entity_out(entity_out)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			table_model.check(ok, id_out, entity_out);
	end

	// Sends one command word; start stays high across back-to-back words.
	task automatic send_word(logic [2:0] op, logic [15:0] id, logic [31:0] ent,
			bit idle = 1'b1);
		int gap;
		gap = idle ? $urandom_range(0, 19) : 0;
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode = op;
		actor_id = id;
		entity = ent;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		table_model.note(op, id, ent);
		if (op == ght_pkg::OP_ALLOCATE && table_model.last_id != 16'd0)
			handles.insert(handles.size(), table_model.last_id);
		if (op == ght_pkg::OP_BIND && table_model.pending[$].ok)
			handles.insert(handles.size(), id);
		if (handles.size() > 64)
			handles.delete(0);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (table_model.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_handle();
		logic [15:0] h;
		if (handles.size() == 0 || $urandom_range(0, 9) == 0)
			h = 16'($urandom);
		else
			h = handles[$urandom_range(0, handles.size() - 1)];
		return h;
	endfunction

	function automatic logic [31:0] pick_entity();
		return ($urandom_range(0, 19) == 0) ? ght_pkg::NULL_ENTITY : $urandom;
	endfunction

	task automatic random_word();
		int roll;
		logic [15:0] h;
		roll = $urandom_range(0, 99);
		h = pick_handle();
		if (roll < 30)
			send_word(ght_pkg::OP_ALLOCATE, 16'd0, pick_entity());
		else if (roll < 45)
			send_word(ght_pkg::OP_RELEASE, h, 32'd0);
		else if (roll < 60)
			send_word(ght_pkg::OP_RESOLVE, h, 32'd0);
		else if (roll < 70)
			send_word(ght_pkg::OP_UNBIND, h, 32'd0);
		else if (roll < 82)
			// Mostly small indexes so the table grows slowly.
			send_word(ght_pkg::OP_BIND, {8'($urandom_range(0, 255)),
				8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 40))}, pick_entity());
		else if (roll < 90)
			// Reuse the slot's current entity only from a slot that the table holds.
			send_word(ght_pkg::OP_BIND, h,
				(($urandom_range(0, 1) == 0) || h[7:0] >= table_model.slot_count)
				? 32'($urandom) : table_model.slot_ent[h[7:0]]);
		else if (roll < 92)
			send_word(ght_pkg::OP_CLEAR, 16'($urandom), $urandom);
		else
			send_word(3'($urandom), 16'($urandom), $urandom);
	endtask

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		table_model = new();
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = ght_pkg::OP_CLEAR;
		actor_id = 16'd0;
		entity = 32'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words: bad ids, null entities, spare opcodes and the slot lifecycle.
		send_word(ght_pkg::OP_RESOLVE, 16'h0101, 32'd0);
		send_word(ght_pkg::OP_BIND, 16'h0000, 32'h1234_5678);
		send_word(ght_pkg::OP_BIND, 16'h0100, 32'h1234_5678);
		send_word(ght_pkg::OP_BIND, 16'h0005, 32'h1234_5678);
		send_word(ght_pkg::OP_BIND, 16'h0305, ght_pkg::NULL_ENTITY);
		send_word(ght_pkg::OP_ALLOCATE, 16'hFFFF, ght_pkg::NULL_ENTITY);
		send_word(ght_pkg::OP_ALLOCATE, 16'h0000, 32'h0000_0000);
		send_word(ght_pkg::OP_BIND, 16'h0305, 32'hA5A5_5A5A);
		send_word(ght_pkg::OP_BIND, 16'h0305, 32'hA5A5_5A5A);
		send_word(ght_pkg::OP_BIND, 16'h0405, 32'hA5A5_5A5A);
		send_word(ght_pkg::OP_RELEASE, 16'h0305, 32'd0);
		send_word(ght_pkg::OP_UNBIND, 16'h0305, 32'd0);
		send_word(ght_pkg::OP_ALLOCATE, 16'h0000, 32'hDEAD_BEEF);
		send_word(ght_pkg::OP_RESOLVE, handles[$], 32'd0);
		send_word(ght_pkg::OP_RELEASE, handles[$], 32'd0);
		send_word(ght_pkg::OP_BIND, 16'hFFFF, 32'hFFFF_FFFE);
		send_word(ght_pkg::OP_UNBIND, 16'hFFFF, 32'd0);
		send_word(ght_pkg::OP_BIND, 16'hFF07, 32'h0000_0007);
		send_word(ght_pkg::OP_ALLOCATE, 16'h0000, 32'h7777_0000);
		send_word(ght_pkg::OP_RELEASE, 16'hFF07, 32'd0);
		send_word(ght_pkg::OP_RESOLVE, 16'hFF07, 32'd0);
		send_word(OP_SPARE_A, 16'h0305, 32'h1111_1111);
		send_word(OP_SPARE_B, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(ght_pkg::OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
		drain();

		// Fill the table until allocation fails, the sender mostly not idling.
		for (int i = 0; i < 260; i++)
			send_word(ght_pkg::OP_ALLOCATE, 16'd0, $urandom, ($urandom_range(0, 9) == 0));
		for (int i = 0; i < 40; i++)
			send_word(ght_pkg::OP_RELEASE, pick_handle(), 32'd0);
		for (int i = 0; i < 30; i++)
			send_word(ght_pkg::OP_ALLOCATE, 16'd0, $urandom);
		drain();

		for (int i = 0; i < 1000; i++) begin
			random_word();
			if (i == 500)
				drain();
		end
		drain();
		repeat (20) @(posedge clk);
		if (table_model.errors == 0 && table_model.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ght_pkg.sv
rtl/ght_ram.sv
rtl/generational_handle_table_unit.sv
bench/tb_generational_handle_table_unit.sv
